FILE: sv/frp_pkg.sv
// Package of shared types, codes and the CRC function for the front-end record parser.
`default_nettype none

package frp_pkg;

    // Stream constants.
    localparam logic [15:0] MARKER_WORD        = 16'hfeed;
    localparam logic [15:0] CRC_POLY           = 16'h8005;
    localparam logic [15:0] CRC_INIT           = 16'hffff;
    localparam logic [31:0] ROLLOVER_STEP      = 32'h0010_0000;
    localparam logic [16:0] FIRST_SAMPLE_INDEX = 17'd9;
    localparam logic [15:0] MIN_LENGTH         = 16'd8;

    // Header word positions within a record.
    localparam logic [16:0] POS_LENGTH  = 17'd1;
    localparam logic [16:0] POS_CHANNEL = 17'd3;
    localparam logic [16:0] POS_CROSS_H = 17'd4;
    localparam logic [16:0] POS_CROSS_L = 17'd5;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Result kinds.
    localparam logic [2:0] KIND_SAMPLE   = 3'd0;
    localparam logic [2:0] KIND_GOOD     = 3'd1;
    localparam logic [2:0] KIND_CRC_BAD  = 3'd2;
    localparam logic [2:0] KIND_ADDR_BAD = 3'd3;
    localparam logic [2:0] KIND_SHORT    = 3'd4;

    // Input transaction.
    typedef struct packed {
        logic [15:0] data_word;
        logic        stream_start;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic [2:0]  item_kind;
        logic [7:0]  channel_index;
        logic [31:0] sample_time;
        logic [15:0] sample_value;
    } t_out_item;

    // Commands passed from the front to the back.
    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_VERDICT,
        CMD_BASE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [2:0]  kind;
        logic [7:0]  chan;
        logic [31:0] time_base;
        logic [15:0] value;
    } t_cmd;

    // Push request from the front into the queue.
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    // CRC-16, MSB first over one 16-bit word, no final inversion.
    function automatic logic [15:0] crc_word(input logic [15:0] crc, input logic [15:0] w);
        logic [15:0] c;
        c = crc ^ w;
        for (int k = 0; k < 16; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/frp_front.sv
// Front part: hunts for records, captures header fields, runs the CRC and issues commands.
`default_nettype none

module frp_front
    import frp_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_accept,
    input  t_in_item i_item,
    output t_push    o_push
);

    logic        r_hunting,    n_hunting;
    logic [15:0] r_pos,        n_pos;
    logic [15:0] r_len,        n_len;
    logic [7:0]  r_chan,       n_chan;
    logic        r_addr_bad,   n_addr_bad;
    logic [19:0] r_cross,      n_cross;
    logic [19:0] r_prev,       n_prev;
    logic [19:0] r_first,      n_first;
    logic        r_first_seen, n_first_seen;
    logic [31:0] r_roll,       n_roll;
    logic [15:0] r_crc,        n_crc;

    // Working copy of the state, cleared when a new stream begins.
    logic        c_hunting;
    logic [15:0] c_pos;
    logic [15:0] c_len;
    logic [7:0]  c_chan;
    logic        c_addr_bad;
    logic [19:0] c_cross;
    logic [19:0] c_prev;
    logic [19:0] c_first;
    logic        c_first_seen;
    logic [31:0] c_roll;
    logic [15:0] c_crc;

    logic [15:0] w;
    logic [16:0] idx;
    logic [19:0] cross5;
    logic [19:0] first5;
    logic [3:0]  addr;

    assign w = i_item.data_word;

    // Classify the word and work out the next parser state.
    always_comb begin
        c_hunting    = r_hunting;
        c_pos        = r_pos;
        c_len        = r_len;
        c_chan       = r_chan;
        c_addr_bad   = r_addr_bad;
        c_cross      = r_cross;
        c_prev       = r_prev;
        c_first      = r_first;
        c_first_seen = r_first_seen;
        c_roll       = r_roll;
        c_crc        = r_crc;
        if (i_item.stream_start) begin
            c_hunting    = 1'b1;
            c_pos        = '0;
            c_len        = '0;
            c_chan       = '0;
            c_addr_bad   = 1'b0;
            c_cross      = '0;
            c_prev       = '0;
            c_first      = '0;
            c_first_seen = 1'b0;
            c_roll       = '0;
            c_crc        = CRC_INIT;
        end

        n_hunting    = c_hunting;
        n_pos        = c_pos;
        n_len        = c_len;
        n_chan       = c_chan;
        n_addr_bad   = c_addr_bad;
        n_cross      = c_cross;
        n_prev       = c_prev;
        n_first      = c_first;
        n_first_seen = c_first_seen;
        n_roll       = c_roll;
        n_crc        = c_crc;

        o_push           = '0;
        o_push.cmd.op    = CMD_SAMPLE;
        idx              = {1'b0, c_pos} + 17'd1;
        cross5           = {c_cross[19:4], w[3:0]};
        first5           = c_first_seen ? c_first : cross5;
        addr             = w[8:5];

        if (c_hunting) begin
            if (w == MARKER_WORD) begin
                n_hunting  = 1'b0;
                n_pos      = '0;
                n_len      = '0;
                n_chan     = '0;
                n_addr_bad = 1'b0;
                n_cross    = '0;
                n_crc      = crc_word(CRC_INIT, w);
            end
        end else if (idx >= 17'd2 && idx == ({1'b0, c_len} + 17'd1)) begin
            // CRC word closes the record with a verdict.
            o_push.push     = 1'b1;
            o_push.cmd.op   = CMD_VERDICT;
            o_push.cmd.chan = c_chan;
            if (w != c_crc) begin
                o_push.cmd.kind = KIND_CRC_BAD;
            end else if (c_addr_bad) begin
                o_push.cmd.kind = KIND_ADDR_BAD;
            end else begin
                o_push.cmd.kind = KIND_GOOD;
            end
            n_hunting = 1'b1;
            n_pos     = '0;
            n_crc     = CRC_INIT;
        end else begin
            n_crc = crc_word(c_crc, w);
            n_pos = idx[15:0];
            if (idx == POS_LENGTH) begin
                n_len = w;
                if (w < MIN_LENGTH) begin
                    o_push.push     = 1'b1;
                    o_push.cmd.op   = CMD_VERDICT;
                    o_push.cmd.kind = KIND_SHORT;
                    n_hunting       = 1'b1;
                    n_pos           = '0;
                    n_crc           = CRC_INIT;
                end
            end else if (idx == POS_CHANNEL) begin
                n_chan     = {addr[2:0], w[4:0]};
                n_addr_bad = addr[3];
            end else if (idx == POS_CROSS_H) begin
                n_cross = {w, 4'b0000};
            end else if (idx == POS_CROSS_L) begin
                // Unwrap the crossing count and hand the time base to the back.
                n_cross = cross5;
                if (cross5 < c_prev) begin
                    n_roll = c_roll + ROLLOVER_STEP;
                end
                n_prev               = cross5;
                n_first              = first5;
                n_first_seen         = 1'b1;
                o_push.push          = 1'b1;
                o_push.cmd.op        = CMD_BASE;
                o_push.cmd.time_base = {12'b0, cross5} + n_roll - {12'b0, first5};
            end else if (idx >= FIRST_SAMPLE_INDEX && !c_addr_bad) begin
                o_push.push      = 1'b1;
                o_push.cmd.op    = CMD_SAMPLE;
                o_push.cmd.chan  = c_chan;
                o_push.cmd.value = w;
            end
        end

        o_push.push = o_push.push & i_accept;
    end

    // Parser state, updated on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting    <= 1'b1;
            r_pos        <= '0;
            r_len        <= '0;
            r_chan       <= '0;
            r_addr_bad   <= 1'b0;
            r_cross      <= '0;
            r_prev       <= '0;
            r_first      <= '0;
            r_first_seen <= 1'b0;
            r_roll       <= '0;
            r_crc        <= CRC_INIT;
        end else if (i_accept) begin
            r_hunting    <= n_hunting;
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_chan       <= n_chan;
            r_addr_bad   <= n_addr_bad;
            r_cross      <= n_cross;
            r_prev       <= n_prev;
            r_first      <= n_first;
            r_first_seen <= n_first_seen;
            r_roll       <= n_roll;
            r_crc        <= n_crc;
        end
    end

endmodule

`default_nettype wire

FILE: sv/frp_queue.sv
// Short command queue between the front and the back parts.
`default_nettype none

module frp_queue
    import frp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_push i_push,
    input  wire   i_pop,
    output t_cmd  o_head,
    output logic  o_valid,
    output logic  o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    // Pointer advance with wrap at the depth.
    always_comb begin
        n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push.push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push.push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/frp_back.sv
// Back part: keeps the running sample time and drives the output register.
`default_nettype none

module frp_back
    import frp_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_cmd      i_head,
    input  wire       i_head_valid,
    output logic      o_pop,
    output logic      o_valid,
    input  wire       i_stall,
    output t_out_item o_data
);

    logic        r_out_valid;
    t_out_item   r_out;
    logic [31:0] r_time;
    logic        out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_head_valid && ((i_head.op == CMD_BASE) || out_free);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.op != CMD_BASE) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Running time and output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_head.op)
                CMD_BASE: begin
                    r_time <= i_head.time_base;
                end
                CMD_SAMPLE: begin
                    r_out.item_kind     <= KIND_SAMPLE;
                    r_out.channel_index <= i_head.chan;
                    r_out.sample_time   <= r_time;
                    r_out.sample_value  <= i_head.value;
                    r_time              <= r_time + 32'd1;
                end
                CMD_VERDICT: begin
                    r_out.item_kind     <= i_head.kind;
                    r_out.channel_index <= i_head.chan;
                    r_out.sample_time   <= '0;
                    r_out.sample_value  <= '0;
                end
                default: begin
                    r_out <= r_out;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/fee_record_parser_crc_check.sv
// Top level of the front-end record parser with CRC check.
//
// The input channel takes one 16-bit stream word per transaction together with
// a stream_start flag that clears the front's parser and timing state before
// the word is parsed. The output channel gives samples and one verdict per record.
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low.
// One word is accepted every cycle while the command queue has room; each
// word produces at most one queue command, and the back part retires one
// command per cycle while i_stall is low, so the sustained rate is one word
// per clock. The accepting edge writes a word's command into the queue, and
// the edge that pops it loads the output register once that register is free.
// When the receiver stalls, the output register holds its transaction and the
// queue fills; o_stall rises once the queue holds QUEUE_DEPTH commands, and
// falls again on the cycle after the back part takes one out.
// Synchronous reset puts the parser back into marker hunting, clears the
// crossing-count history and empties the queue and the output register.
`default_nettype none

module fee_record_parser_crc_check
    import frp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  wire       i_stall,
    output t_out_item o_data
);

    logic  accept;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_push push;
    t_cmd  q_head;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // Front part: parsing and CRC.
    frp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_push   (push)
    );

    // Command queue.
    frp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // Back part: timing and output register.
    frp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (q_valid),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule

`default_nettype wire
